// File: rtl/core/ttsi_pkg.sv
// Shared types and constants for the timestamp to sample index block.
// Used by ttsi_div and timestamp_to_sample_index; no dependencies.
package ttsi_pkg;

    // Offset table geometry
    localparam int MAX_SAMPLES = 4096;
    localparam int IDX_W       = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = IDX_W + 1;

    // Field widths
    localparam int TIME_W  = 64;
    localparam int PHASE_W = 41;
    localparam int SCALE_W = 40;

    // Stream word widths (fields packed from bit 0, padded to bytes)
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PHASE_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_PHASE = 2'd0,
        CFG_TIMESCALE     = 2'd1,
        CFG_SAMPLE_COUNT  = 2'd2,
        CFG_UNIFORM_MODE  = 2'd3
    } t_cfg_idx;

    // Item kind carried on tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Sign bit of a 64-bit value; XOR with it maps signed order to unsigned order
    localparam logic [TIME_W-1:0] SIGN64 = {1'b1, {(TIME_W-1){1'b0}}};

    // Divider result handed back to the sequencer
    typedef struct packed {
        logic              busy;
        logic [TIME_W-1:0] quo;
        logic              rem_nz;
    } t_div_stat;

endpackage

// File: rtl/core/ttsi_div.sv
// Restoring unsigned divider, 64-bit dividend by 40-bit divisor, one bit a cycle.
// Depends on ttsi_pkg.
module ttsi_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ttsi_pkg::TIME_W-1:0]  i_dividend,
    input  logic [ttsi_pkg::SCALE_W-1:0] i_divisor,
    output ttsi_pkg::t_div_stat          o_stat
);

    localparam int CNT_W = $clog2(ttsi_pkg::TIME_W);

    logic                         r_busy;
    logic [CNT_W-1:0]             r_cnt;
    logic [ttsi_pkg::TIME_W-1:0]  r_quo;
    logic [ttsi_pkg::SCALE_W-1:0] r_rem;
    logic [ttsi_pkg::SCALE_W-1:0] r_den;

    logic [ttsi_pkg::SCALE_W:0]   w_shift;
    logic [ttsi_pkg::SCALE_W+1:0] w_trial;

    // One restoring step: shift in the next dividend bit, try subtracting
    assign w_shift = {r_rem, r_quo[ttsi_pkg::TIME_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '1;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!w_trial[ttsi_pkg::SCALE_W+1]) begin
                r_rem <= w_trial[ttsi_pkg::SCALE_W-1:0];
                r_quo <= {r_quo[ttsi_pkg::TIME_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[ttsi_pkg::SCALE_W-1:0];
                r_quo <= {r_quo[ttsi_pkg::TIME_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy   = r_busy;
    assign o_stat.quo    = r_quo;
    assign o_stat.rem_nz = |r_rem;

endmodule

// File: rtl/core/timestamp_to_sample_index.sv
// Timestamp to sample index: offset table, floor-divide sequencer, bisection search.
// Depends on ttsi_pkg and ttsi_div.
// Load word: written to the table at the edge that accepts it; loads can stream.
// Query word: the divider runs and the sequencer waits to see it finish, then a check state,
// then (sparse) the two end-point reads and one registered table read per bisection probe
// (up to 12), then the output register; the input is ready again once the result is in it.
// A result still held by the output stalls the next query. One word at a time.
// Reset (synchronous, active low) clears control and config; the table is left as is.
module timestamp_to_sample_index (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [ttsi_pkg::S_TDATA_W-1:0]   i_s_tdata,  // entry_index, entry_offset, query_time
    input  logic                             i_s_tuser,  // op
    // Result stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [ttsi_pkg::M_TDATA_W-1:0]   o_m_tdata,  // sample_index
    output logic                             o_m_tuser,  // clipped flag
    // Configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ttsi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ttsi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int IW = ttsi_pkg::IDX_W;
    localparam int CW = ttsi_pkg::CNT_W;
    localparam int TW = ttsi_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CHK,
        S_FIRST,
        S_LAST,
        S_SRCH,
        S_OUT
    } t_state;

    // Config registers
    logic [ttsi_pkg::PHASE_W-1:0] r_phase;
    logic [ttsi_pkg::SCALE_W-1:0] r_scale;
    logic [CW-1:0]                r_count;
    logic                         r_uniform;

    // Sequencer registers
    t_state         r_state, n_state;
    logic           r_neg, n_neg;
    logic           r_above, n_above;
    logic           r_below, n_below;
    logic [TW-1:0]  r_tb, n_tb;
    logic [IW-1:0]  r_lo, n_lo;
    logic [IW-1:0]  r_hi, n_hi;
    logic [IW-1:0]  r_res_idx, n_res_idx;
    logic           r_res_oob, n_res_oob;
    logic           r_m_tvalid, n_m_tvalid;
    logic [IW-1:0]  r_m_idx, n_m_idx;
    logic           r_m_oob, n_m_oob;

    // Table
    logic [TW-1:0]  r_table [ttsi_pkg::MAX_SAMPLES];
    logic [TW-1:0]  r_rd_data;
    logic [IW-1:0]  w_rd_addr;

    // Input fields
    logic [IW-1:0]  w_entry_index;
    logic [TW-1:0]  w_entry_offset;
    logic [TW-1:0]  w_query_time;

    logic                         w_s_acc;
    logic [TW-1:0]                w_phase_x;
    logic                         w_ge;
    logic [TW-1:0]                w_mag;
    logic [ttsi_pkg::SCALE_W-1:0] w_scale;
    logic                         w_div_start;
    ttsi_pkg::t_div_stat          w_div;
    logic [TW-1:0]                w_qn;
    logic [CW-1:0]                w_count;
    logic [IW-1:0]                w_last;
    logic [TW-1:0]                w_data_b;
    logic [IW-1:0]                w_span;
    logic [IW-1:0]                w_mid;

    assign w_entry_index  = i_s_tdata[IW-1:0];
    assign w_entry_offset = i_s_tdata[IW+TW-1:IW];
    assign w_query_time   = i_s_tdata[IW+2*TW-1:IW+TW];

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;

    // Time minus trigger phase, as a magnitude plus a sign
    assign w_phase_x   = {{(TW-ttsi_pkg::PHASE_W){r_phase[ttsi_pkg::PHASE_W-1]}}, r_phase};
    assign w_ge        = $signed(w_query_time) >= $signed(w_phase_x);
    assign w_mag       = w_ge ? (w_query_time - w_phase_x) : (w_phase_x - w_query_time);
    assign w_scale     = (r_scale == '0) ? ttsi_pkg::SCALE_W'(1) : r_scale;
    assign w_div_start = w_s_acc && (i_s_tuser == ttsi_pkg::OP_QUERY);

    ttsi_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (w_scale),
        .o_stat     (w_div)
    );

    // Ceiling of the magnitude for negative differences
    assign w_qn = w_div.quo + TW'(w_div.rem_nz);

    // Clipped sample count and last index
    assign w_count  = (r_count > CW'(ttsi_pkg::MAX_SAMPLES)) ?
                      CW'(ttsi_pkg::MAX_SAMPLES) : r_count;
    assign w_last   = IW'(w_count - 1'b1);
    assign w_data_b = r_rd_data ^ ttsi_pkg::SIGN64;
    assign w_span   = r_hi - r_lo;
    assign w_mid    = r_lo + (w_span >> 1);

    // Sequencer
    always_comb begin
        logic [IW-1:0] v_lo;
        logic [IW-1:0] v_hi;
        logic [IW-1:0] v_span;
        v_lo       = r_lo;
        v_hi       = r_hi;
        v_span     = '0;
        n_state    = r_state;
        n_neg      = r_neg;
        n_above    = r_above;
        n_below    = r_below;
        n_tb       = r_tb;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_res_idx  = r_res_idx;
        n_res_oob  = r_res_oob;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_idx    = r_m_idx;
        n_m_oob    = r_m_oob;
        w_rd_addr  = '0;
        case (r_state)
            S_IDLE: begin
                if (w_div_start) begin
                    n_neg   = !w_ge;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_div.busy) begin
                    if (!r_neg) begin
                        n_above = w_div.quo[TW-1];
                        n_below = 1'b0;
                        n_tb    = {1'b1, w_div.quo[TW-2:0]};
                    end else begin
                        n_above = 1'b0;
                        n_below = w_qn[TW-1] && (|w_qn[TW-2:0]);
                        n_tb    = ttsi_pkg::SIGN64 - w_qn;
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                // table address 0 goes out here for the sparse case
                if (w_count == '0) begin
                    n_res_idx = '0;
                    n_res_oob = 1'b1;
                    n_state   = S_OUT;
                end else if (r_uniform) begin
                    if (r_below || !r_tb[TW-1]) begin
                        n_res_idx = '0;
                        n_res_oob = 1'b1;
                    end else if (r_above || (r_tb[TW-2:0] >= (TW-1)'(w_count))) begin
                        n_res_idx = w_last;
                        n_res_oob = 1'b1;
                    end else begin
                        n_res_idx = r_tb[IW-1:0];
                        n_res_oob = 1'b0;
                    end
                    n_state = S_OUT;
                end else begin
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                w_rd_addr = w_last;
                if (r_below || (!r_above && (r_tb <= w_data_b))) begin
                    n_res_idx = '0;
                    n_res_oob = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_lo = '0;
                n_hi = w_last;
                if (r_above || (r_tb > w_data_b)) begin
                    n_res_idx = w_last;
                    n_res_oob = 1'b1;
                    n_state   = S_OUT;
                end else if (r_tb == w_data_b) begin
                    n_res_idx = w_last;
                    n_res_oob = 1'b0;
                    n_state   = S_OUT;
                end else if (w_last > IW'(1)) begin
                    // first probe: midpoint of 0 .. last
                    w_rd_addr = w_last >> 1;
                    n_state   = S_SRCH;
                end else begin
                    n_res_idx = '0;
                    n_res_oob = 1'b0;
                    n_state   = S_OUT;
                end
            end
            S_SRCH: begin
                // read data is the entry at the current midpoint
                if (w_data_b <= r_tb) begin
                    v_lo = w_mid;
                end else begin
                    v_hi = w_mid;
                end
                v_span    = v_hi - v_lo;
                n_lo      = v_lo;
                n_hi      = v_hi;
                w_rd_addr = v_lo + (v_span >> 1);
                if (v_span <= IW'(1)) begin
                    n_res_idx = v_lo;
                    n_res_oob = 1'b0;
                    n_state   = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_idx    = r_res_idx;
                    n_m_oob    = r_res_oob;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= n_m_tvalid;
        end
        r_neg     <= n_neg;
        r_above   <= n_above;
        r_below   <= n_below;
        r_tb      <= n_tb;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_res_idx <= n_res_idx;
        r_res_oob <= n_res_oob;
        r_m_idx   <= n_m_idx;
        r_m_oob   <= n_m_oob;
    end

    // Offset table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_s_acc && (i_s_tuser == ttsi_pkg::OP_LOAD)) begin
            r_table[w_entry_index] <= w_entry_offset;
        end
        r_rd_data <= r_table[w_rd_addr];
    end

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_scale   <= ttsi_pkg::SCALE_W'(1);
            r_count   <= '0;
            r_uniform <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (ttsi_pkg::t_cfg_idx'(i_cfg_index))
                ttsi_pkg::CFG_TRIGGER_PHASE: r_phase   <= i_cfg_data;
                ttsi_pkg::CFG_TIMESCALE:     r_scale   <= i_cfg_data[ttsi_pkg::SCALE_W-1:0];
                ttsi_pkg::CFG_SAMPLE_COUNT:  r_count   <= i_cfg_data[CW-1:0];
                ttsi_pkg::CFG_UNIFORM_MODE:  r_uniform <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(ttsi_pkg::M_TDATA_W-IW){1'b0}}, r_m_idx};
    assign o_m_tuser  = r_m_oob;

`ifndef SYNTHESIS
    // A query word starts the divider at once
    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> w_div.busy)
        else $error("divider not busy after query accept");

    // Bisection keeps a nonempty bracket
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi))
        else $error("search bracket collapsed");

    // Out-of-range target is either above or below, never both
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> !(r_above && r_below))
        else $error("target flagged above and below");

    // An in-range result indexes a valid sample
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !r_m_oob) |-> ({1'b0, r_m_idx} < w_count))
        else $error("in-range result beyond sample count");
`endif

endmodule

// File: sim/timestamp_to_sample_index_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for timestamp_to_sample_index: directed and random load/query words
// are checked against an in-bench floor-division and bisection predictor.
// Depends on ttsi_pkg and the timestamp_to_sample_index RTL.
module timestamp_to_sample_index_tb;

    localparam int TIME_W      = ttsi_pkg::TIME_W;
    localparam int PHASE_W     = ttsi_pkg::PHASE_W;
    localparam int SCALE_W     = ttsi_pkg::SCALE_W;
    localparam int IDX_W       = ttsi_pkg::IDX_W;
    localparam int CNT_W       = ttsi_pkg::CNT_W;
    localparam int MAX_SAMPLES = ttsi_pkg::MAX_SAMPLES;
    localparam int S_TDATA_W   = ttsi_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = ttsi_pkg::M_TDATA_W;
    localparam int CFG_IDX_W   = ttsi_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = ttsi_pkg::CFG_DATA_W;

    localparam int TOTAL_ITEMS   = 1850;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int BIG_COUNT     = 1024;

    localparam logic [TIME_W-1:0]  MIN64  = 64'h8000_0000_0000_0000;
    localparam logic [TIME_W-1:0]  MAX64  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [PHASE_W-1:0] PH_MIN = 41'h100_0000_0000;
    localparam logic [PHASE_W-1:0] PH_MAX = 41'h0FF_FFFF_FFFF;
    localparam logic [SCALE_W-1:0] SC_MAX = 40'hFF_FFFF_FFFF;
    localparam logic signed [127:0] T_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] T_MIN = -T_MAX - 1;

    // One input word, fields as the stream carries them
    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [TIME_W-1:0] entry_offset;
        logic [TIME_W-1:0] query_time;
    } t_item;

    // One result word
    typedef struct packed {
        logic [IDX_W-1:0] sample_index;
        logic             clip_flag;
    } t_hit;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;  // entry_index, entry_offset, query_time
    logic                  i_s_tuser   = 1'b0; // op
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;         // sample_index
    logic                  o_m_tuser;         // clipped flag
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    timestamp_to_sample_index u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: offset table and register copies
    logic [TIME_W-1:0]  ofs_tbl [MAX_SAMPLES];
    logic [PHASE_W-1:0] phase_reg = '0;
    logic [SCALE_W-1:0] scale_reg = 40'd1;
    logic [CNT_W-1:0]   count_reg = '0;
    logic               uni_reg   = 1'b0;

    // Stimulus side copy of the table, for aiming queries at offsets
    logic [TIME_W-1:0]  aim_tbl [MAX_SAMPLES];

    t_item word_q [$];
    t_hit  hit_q  [$];
    int    n_queued = 0;
    int    n_taken  = 0;
    int    n_fail   = 0;
    int    n_cycles = 0;
    bit    calm     = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic signed [127:0] wide64(logic [TIME_W-1:0] v);
        return {{64{v[TIME_W-1]}}, v};
    endfunction

    function automatic logic signed [127:0] phase_wide();
        return {{(128-PHASE_W){phase_reg[PHASE_W-1]}}, phase_reg};
    endfunction

    // zero timescale behaves as one
    function automatic logic signed [127:0] scale_wide();
        logic signed [127:0] d;
        d = {{(128-SCALE_W){1'b0}}, scale_reg};
        if (scale_reg == '0)
            d = 1;
        return d;
    endfunction

    // Floor of (time - phase) / scale, then clip or bisect into the table
    function automatic t_hit locate_sample(logic [TIME_W-1:0] qt);
        logic signed [127:0] num, den, tgt;
        int   cnt, lo, hi, mid;
        t_hit h;
        cnt = (count_reg > MAX_SAMPLES) ? MAX_SAMPLES : int'(count_reg);
        num = wide64(qt) - phase_wide();
        den = scale_wide();
        tgt = num / den;
        if (num < 0 && (num % den) != 0)
            tgt = tgt - 1;
        h.sample_index = '0;
        h.clip_flag    = 1'b1;
        if (cnt == 0) begin
            // empty waveform keeps index 0, flagged
        end else if (uni_reg) begin
            if (tgt >= cnt) begin
                h.sample_index = IDX_W'(cnt - 1);
            end else if (tgt >= 0) begin
                h.sample_index = tgt[IDX_W-1:0];
                h.clip_flag    = 1'b0;
            end
        end else if (tgt <= wide64(ofs_tbl[0])) begin
            // at or below the first offset
        end else if (tgt > wide64(ofs_tbl[IDX_W'(cnt - 1)])) begin
            h.sample_index = IDX_W'(cnt - 1);
        end else begin
            h.clip_flag = 1'b0;
            if (tgt == wide64(ofs_tbl[IDX_W'(cnt - 1)])) begin
                h.sample_index = IDX_W'(cnt - 1);
            end else begin
                // off[lo] <= target < off[hi] holds through the loop
                lo = 0;
                hi = cnt - 1;
                while (hi - lo > 1) begin
                    mid = lo + (hi - lo) / 2;
                    if (wide64(ofs_tbl[IDX_W'(mid)]) <= tgt)
                        lo = mid;
                    else
                        hi = mid;
                end
                h.sample_index = IDX_W'(lo);
            end
        end
        return h;
    endfunction

    // Query time that lands on a given tick target, with a jitter inside it or just outside it
    function automatic logic [TIME_W-1:0] time_for_target(logic signed [127:0] tgt);
        logic signed [127:0] den, t, jit;
        den = scale_wide();
        jit = '0;
        jit[TIME_W-1:0] = rand64() % den[TIME_W-1:0];
        case ($urandom_range(7))
            0: jit = -1;
            1: jit = den;
            2: jit = 0;
            default: ;
        endcase
        t = tgt * den + phase_wide() + jit;
        if (t > T_MAX)
            t = T_MAX;
        else if (t < T_MIN)
            t = T_MIN;
        return t[TIME_W-1:0];
    endfunction

    // Input word driver
    always @(posedge i_clk) begin : drive_words
        t_item nxt;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (word_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
                nxt = word_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {4'd0, nxt.query_time, nxt.entry_offset, nxt.entry_index};
                i_s_tuser  <= nxt.op;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_m_tready <= 1'b0;
        else
            i_m_tready <= calm || ($urandom_range(99) >= 16);
    end

    // Accepted input words update the predictor
    always @(posedge i_clk) begin : watch_input
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            n_taken++;
            if (i_s_tuser == ttsi_pkg::OP_LOAD)
                ofs_tbl[i_s_tdata[IDX_W-1:0]] = i_s_tdata[IDX_W +: TIME_W];
            else
                hit_q.push_back(locate_sample(i_s_tdata[IDX_W+TIME_W +: TIME_W]));
        end
    end

    // Accepted result words against the oldest expectation
    always @(posedge i_clk) begin : watch_output
        t_hit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (hit_q.size() == 0) begin
                $error("result word with no query pending: sample_index %0d clip_flag %0b",
                       o_m_tdata[IDX_W-1:0], o_m_tuser);
                n_fail++;
            end else begin
                want = hit_q.pop_front();
                if (o_m_tdata[IDX_W-1:0] !== want.sample_index) begin
                    $error("sample_index: expected %0d, actual %0d",
                           want.sample_index, o_m_tdata[IDX_W-1:0]);
                    n_fail++;
                end
                if (o_m_tuser !== want.clip_flag) begin
                    $error("clip_flag: expected %0b, actual %0b",
                           want.clip_flag, o_m_tuser);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_word(logic op, logic [IDX_W-1:0] idx, logic [TIME_W-1:0] ofs,
                             logic [TIME_W-1:0] qt);
        t_item w;
        w.op           = op;
        w.entry_index  = idx;
        w.entry_offset = ofs;
        w.query_time   = qt;
        word_q.push_back(w);
        n_queued++;
        if (op == ttsi_pkg::OP_LOAD)
            aim_tbl[idx] = ofs;
    endtask

    task automatic load_entry(int idx, logic [TIME_W-1:0] ofs);
        push_word(ttsi_pkg::OP_LOAD, IDX_W'(idx), ofs, rand64());
    endtask

    task automatic query_at(logic [TIME_W-1:0] qt);
        push_word(ttsi_pkg::OP_QUERY, IDX_W'($urandom), rand64(), qt);
    endtask

    // Block idle: every word taken, every result back, then settle
    task automatic wait_idle();
        do @(posedge i_clk); while (n_taken != n_queued || hit_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(ttsi_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ttsi_pkg::CFG_TRIGGER_PHASE: phase_reg = val[PHASE_W-1:0];
            ttsi_pkg::CFG_TIMESCALE:     scale_reg = val[SCALE_W-1:0];
            ttsi_pkg::CFG_SAMPLE_COUNT:  count_reg = val[CNT_W-1:0];
            ttsi_pkg::CFG_UNIFORM_MODE:  uni_reg   = val[0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [PHASE_W-1:0] ph, logic [SCALE_W-1:0] sc,
                           logic [CNT_W-1:0] cnt, logic uni);
        wait_idle();
        cfg_write(ttsi_pkg::CFG_TRIGGER_PHASE, CFG_DATA_W'(ph));
        cfg_write(ttsi_pkg::CFG_TIMESCALE, CFG_DATA_W'(sc));
        cfg_write(ttsi_pkg::CFG_SAMPLE_COUNT, CFG_DATA_W'(cnt));
        cfg_write(ttsi_pkg::CFG_UNIFORM_MODE, CFG_DATA_W'(uni));
    endtask

    // Entries 0..eff-1: sorted with random steps, sorted with repeats, or unsorted
    task automatic fill_table(int eff);
        logic signed [127:0] cur;
        int j, kind, step;
        kind = $urandom_range(9);
        cur  = wide64(rand64()) >>> $urandom_range(8, 63);
        for (j = 0; j < eff; j++) begin
            if (kind == 0) begin
                load_entry(j, rand64());
            end else begin
                if (kind < 3)
                    step = $urandom_range(2);
                else
                    step = $urandom_range(1, 1 << $urandom_range(20));
                if (j > 0)
                    cur = cur + step;
                load_entry(j, cur[TIME_W-1:0]);
            end
        end
    endtask

    // Queries aimed at offsets or the uniform range, random times, and stray loads
    task automatic push_mix(int nq, int eff, bit hold_mid);
        logic signed [127:0] tgt;
        int k, d;
        for (k = 0; k < nq; k++) begin
            if (hold_mid && k == nq / 2)
                wait_idle();
            case ($urandom_range(19))
                0, 1, 2: begin
                    // stray load away from the searched entries
                    if (uni_reg)
                        load_entry($urandom_range(MAX_SAMPLES - 1), rand64());
                    else
                        load_entry($urandom_range(MAX_SAMPLES - 1, eff), rand64());
                end
                3, 4, 5, 6: begin
                    case ($urandom_range(9))
                        0: query_at(MIN64);
                        1: query_at(MAX64);
                        default: query_at(rand64());
                    endcase
                end
                default: begin
                    if (!uni_reg && eff > 0) begin
                        d   = int'($urandom_range(2)) - 1;
                        tgt = wide64(aim_tbl[IDX_W'($urandom_range(eff - 1))]) + d;
                    end else begin
                        d   = int'($urandom_range(eff + 5)) - 3;
                        tgt = d;
                    end
                    query_at(time_for_target(tgt));
                end
            endcase
        end
    endtask

    task automatic run_random_phase(bit hold_mid);
        logic [PHASE_W-1:0] ph;
        logic [SCALE_W-1:0] sc;
        int  cnt, eff, d;
        logic uni;
        uni = 1'($urandom_range(1));
        case ($urandom_range(4))
            0: ph = '0;
            1: begin
                d  = int'($urandom_range(2000)) - 1000;
                ph = PHASE_W'(d);
            end
            2: ph = PHASE_W'(rand64());
            3: ph = PH_MIN;
            default: ph = PH_MAX;
        endcase
        case ($urandom_range(5))
            0: sc = 40'd1;
            1: sc = '0;
            2: sc = SCALE_W'($urandom_range(2, 1000));
            3, 4: sc = SCALE_W'(rand64()) >> $urandom_range(SCALE_W - 1);
            default: sc = SC_MAX;
        endcase
        case ($urandom_range(9))
            0: cnt = 0;
            1, 2, 3, 4, 5: cnt = $urandom_range(1, 24);
            6, 7: cnt = $urandom_range(25, 300);
            default: cnt = uni ? $urandom_range(MAX_SAMPLES, (1 << CNT_W) - 1)
                               : $urandom_range(1, 3);
        endcase
        eff = (cnt > MAX_SAMPLES) ? MAX_SAMPLES : cnt;
        cfg_all(ph, sc, CNT_W'(cnt), uni);
        if (!uni)
            fill_table(eff);
        push_mix($urandom_range(10, 40), eff, hold_mid);
    endtask

    // Directed cases: empty waveform, end points, exact matches, range overflow, clipping
    task automatic run_directed();
        // reset config: sparse, empty
        query_at(MIN64);
        load_entry(0, MIN64);
        load_entry(1, -64'sd100);
        load_entry(2, 64'd0);
        load_entry(3, 64'd50);
        load_entry(4, MAX64);
        load_entry(MAX_SAMPLES - 1, 64'h5555_AAAA_5555_AAAA);
        query_at(MAX64);

        // sparse search over four entries
        cfg_all('0, 40'd1, CNT_W'(4), 1'b0);
        query_at(-64'sd200);
        query_at(MIN64);
        query_at(-64'sd100);
        query_at(64'd10);
        query_at(64'd50);
        query_at(64'd51);

        // target one past the 64-bit range, then exactly on the last offset
        cfg_all('1, '0, CNT_W'(5), 1'b0);
        query_at(MAX64);
        query_at(MAX64 - 64'd1);

        // target below the 64-bit range
        wait_idle();
        cfg_write(ttsi_pkg::CFG_TRIGGER_PHASE, CFG_DATA_W'(PH_MAX));
        query_at(MIN64);

        // uniform with count above the table size and the widest timescale
        cfg_all(PH_MIN, SC_MAX, '1, 1'b1);
        query_at(MIN64);
        query_at(MAX64);
        query_at(64'd0);
        query_at(-64'sd1099511627777);
        query_at(-64'sd1099511627776);

        // uniform, empty
        wait_idle();
        cfg_write(ttsi_pkg::CFG_SAMPLE_COUNT, '0);
        query_at(64'd0);

        // uniform, single sample
        cfg_all('0, 40'd3, CNT_W'(1), 1'b1);
        query_at(64'd2);
        query_at(64'd3);
        query_at(-64'sd1);
    endtask

    // Large table loaded sorted and searched, then uniform with an oversized count
    task automatic run_full_table();
        logic signed [127:0] cur;
        int j;
        cfg_all(PHASE_W'($urandom_range(5000)), SCALE_W'($urandom_range(1, 9)),
                CNT_W'(BIG_COUNT), 1'b0);
        cur = -(128'sd1 <<< 62);
        for (j = 0; j < BIG_COUNT; j++) begin
            cur = cur + $urandom_range(1, 1 << 30);
            load_entry(j, cur[TIME_W-1:0]);
        end
        push_mix(60, BIG_COUNT, 1'b0);
        cfg_all(phase_reg, scale_reg, '1, 1'b1);
        push_mix(20, MAX_SAMPLES, 1'b0);
    endtask

    initial begin : stimulus
        int phase_no;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_full_table();
        phase_no = 0;
        while (n_queued < TOTAL_ITEMS) begin
            wait_idle();
            calm = (phase_no == 3);
            run_random_phase(phase_no == 1);
            phase_no++;
        end
        wait_idle();
        calm = 1'b0;
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: timestamp_to_sample_index.f
rtl/core/ttsi_pkg.sv
rtl/core/ttsi_div.sv
rtl/core/timestamp_to_sample_index.sv
sim/timestamp_to_sample_index_tb.sv
